### rtl/ray_circle_intersection_core_macros.svh
// assertion macros for the ray circle intersection core
`ifndef RAY_CIRCLE_INTERSECTION_CORE_MACROS_SVH
`define RAY_CIRCLE_INTERSECTION_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define RCI_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rci implication check failed");

// next-cycle implication, sampled on clock, off during reset
`define RCI_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rci next-cycle check failed");

`endif

### rtl/rci_pkg.sv
// shared types, widths and helpers of the ray circle intersection core
package rci_pkg;

   localparam int FracBits    = 8;
   localparam int CoordWidth  = 24;
   localparam int CenterWidth = 16;
   localparam int RadiusWidth = 15;

   localparam int DiffW  = CoordWidth + 1;
   localparam int ProdW  = 2 * DiffW;
   localparam int L2W    = ProdW;
   localparam int DotW   = ProdW + 1;
   localparam int MagW   = ProdW;
   localparam int HalfW  = MagW / 2;
   localparam int RrW    = 2 * RadiusWidth;
   localparam int RlPW   = RrW + (L2W - HalfW);
   localparam int RlW    = RlPW + HalfW + 2 * FracBits;
   localparam int SqW    = 2 * MagW;
   localparam int RootW  = RlW / 2;
   localparam int RemW   = RootW + 3;
   localparam int KW     = MagW + 1;
   localparam int KLoW   = 26;
   localparam int KHiW   = KW - KLoW;
   localparam int MagDW  = CoordWidth;
   localparam int PLoW   = MagDW + KLoW;
   localparam int PHiW   = MagDW + KHiW;
   localparam int NumW   = MagDW + KW;
   localparam int Num2W  = NumW + 2;
   localparam int QW     = 27;
   localparam int DenW   = L2W + 1;
   localparam int SumW   = QW + 2;
   localparam int Lanes  = 4;

   localparam int SqrtStages = RootW;
   localparam int DivStages  = QW;

   // lane order of the four output coordinates
   localparam int LaneNearX = 0;
   localparam int LaneNearY = 1;
   localparam int LaneFarX  = 2;
   localparam int LaneFarY  = 3;

   typedef struct packed {
      logic [CoordWidth-1:0] ax;
      logic [CoordWidth-1:0] ay;
      logic [DiffW-1:0]      dx;
      logic [DiffW-1:0]      dy;
   } ray_type;

   typedef struct packed {
      logic                  hit;
      ray_type               ray;
      logic [L2W-1:0]        l2;
      logic [MagW-1:0]       dot;
      logic [RlW-1:0]        x;
      logic [RemW-1:0]       rem;
      logic [RootW-1:0]      root;
   } sq_type;

   typedef struct packed {
      logic                  hit;
      ray_type               ray;
      logic [L2W-1:0]        l2;
      logic [KW-1:0]         kn;
      logic [KW-1:0]         kf;
   } k_type;

   typedef struct packed {
      logic                       hit;
      logic [CoordWidth-1:0]      ax;
      logic [CoordWidth-1:0]      ay;
      logic [L2W-1:0]             l2;
      logic [Lanes-1:0]           neg;
      logic [Lanes-1:0][PLoW-1:0] plo;
      logic [Lanes-1:0][PHiW-1:0] phi;
   } mul_type;

   typedef struct packed {
      logic                       hit;
      logic [CoordWidth-1:0]      ax;
      logic [CoordWidth-1:0]      ay;
      logic [Lanes-1:0]           neg;
      logic [DenW-1:0]            den;
      logic [Lanes-1:0][DenW-1:0] rem;
      logic [Lanes-1:0][QW-1:0]   lo;
      logic [Lanes-1:0][QW-1:0]   q;
   } dv_type;

   // start coordinate plus or minus the rounded offset, clamped to the coordinate range
   function automatic logic [CoordWidth-1:0] sat_coord(
      input logic [CoordWidth-1:0] a,
      input logic                  neg,
      input logic [QW-1:0]         q
   );
      logic signed [SumW-1:0] sa;
      logic signed [SumW-1:0] sq;
      logic signed [SumW-1:0] s;
      logic signed [SumW-1:0] hi;
      logic signed [SumW-1:0] lo;
      logic [CoordWidth-1:0]  r;
      sa = $signed({{(SumW-CoordWidth){a[CoordWidth-1]}}, a});
      sq = $signed({{(SumW-QW){1'b0}}, q});
      s  = neg ? sa - sq : sa + sq;
      hi = $signed({{(SumW-CoordWidth+1){1'b0}}, {(CoordWidth-1){1'b1}}});
      lo = -hi - $signed(SumW'(1));
      if (s > hi) begin
         r = hi[CoordWidth-1:0];
      end else if (s < lo) begin
         r = lo[CoordWidth-1:0];
      end else begin
         r = s[CoordWidth-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/ray_circle_intersection_core.sv
// ray circle intersection core: pipelined hit test with near and far points
// One transaction per clock is taken and one result comes out per clock. A transaction
// passes 86 register stages: six front stages for the products and wide compares, 49 square
// root stages (an entry stage, then one root bit per stage), one stage each for the
// intersection parameters and the lane products, 28 divider stages (an entry stage, then
// one quotient bit per stage, four lanes) and the output register. The whole pipeline
// holds while a result waits under rsp_stall, so req_stall follows rsp_stall whenever a
// result is pending.
// A miss, a zero-length ray, a tangent ray or a start inside the circle gives rsp_hit low
// with all four coordinates zero; hit coordinates saturate to the signed 24-bit range.
`include "ray_circle_intersection_core_macros.svh"

module ray_circle_intersection_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rci_pkg::CoordWidth-1:0]      req_start_x,
   input  logic [rci_pkg::CoordWidth-1:0]      req_start_y,
   input  logic [rci_pkg::CoordWidth-1:0]      req_end_x,
   input  logic [rci_pkg::CoordWidth-1:0]      req_end_y,
   input  logic [rci_pkg::CenterWidth-1:0]     req_center_x,
   input  logic [rci_pkg::CenterWidth-1:0]     req_center_y,
   input  logic [rci_pkg::RadiusWidth-1:0]     req_circle_radius,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [rci_pkg::CoordWidth-1:0]      rsp_near_x,
   output logic [rci_pkg::CoordWidth-1:0]      rsp_near_y,
   output logic [rci_pkg::CoordWidth-1:0]      rsp_far_x,
   output logic [rci_pkg::CoordWidth-1:0]      rsp_far_y
);

   localparam int CW = rci_pkg::CoordWidth;
   localparam int HW = rci_pkg::HalfW;
   localparam int Lanes_c = rci_pkg::Lanes;

   logic en;

   // valid bits
   logic [5:0]                     fv_ff;
   logic [rci_pkg::SqrtStages:0]   sv_ff;
   logic                           kv_ff;
   logic                           mv_ff;
   logic [rci_pkg::DivStages:0]    dv_vld_ff;
   logic                           rsp_valid_ff;

   // front stage one
   rci_pkg::ray_type                     s1_ray_in, s1_ray_ff;
   logic signed [rci_pkg::DiffW-1:0]     s1_wx_in, s1_wy_in, s1_wx_ff, s1_wy_ff;
   logic [rci_pkg::RadiusWidth-1:0]      s1_r_ff;
   // front stage two
   rci_pkg::ray_type                     s2_ray_ff;
   logic signed [rci_pkg::ProdW-1:0]     s2_pxx_in, s2_pyy_in, s2_pxw_in, s2_pyw_in;
   logic signed [rci_pkg::ProdW-1:0]     s2_pxwy_in, s2_pywx_in;
   logic signed [rci_pkg::ProdW-1:0]     s2_pxx_ff, s2_pyy_ff, s2_pxw_ff, s2_pyw_ff;
   logic signed [rci_pkg::ProdW-1:0]     s2_pxwy_ff, s2_pywx_ff;
   logic [rci_pkg::RrW-1:0]              s2_rr_in, s2_rr_ff;
   // front stage three
   rci_pkg::ray_type                     s3_ray_ff;
   logic [rci_pkg::L2W-1:0]              s3_l2_in, s3_l2_ff;
   logic signed [rci_pkg::DotW-1:0]      s3_dot_in, s3_cross_in, s3_dot_ff, s3_cross_ff;
   logic [rci_pkg::RrW-1:0]              s3_rr_ff;
   // front stage four
   rci_pkg::ray_type                     s4_ray_ff;
   logic [rci_pkg::L2W-1:0]              s4_l2_ff;
   logic [rci_pkg::MagW-1:0]             s4_cm_in, s4_dm_in, s4_cm_ff, s4_dm_ff;
   logic                                 s4_dneg_ff;
   logic [rci_pkg::RlPW-1:0]             s4_rlh_in, s4_rll_in, s4_rlh_ff, s4_rll_ff;
   // front stage five
   rci_pkg::ray_type                     s5_ray_ff;
   logic [rci_pkg::L2W-1:0]              s5_l2_ff;
   logic [rci_pkg::MagW-1:0]             s5_dm_ff;
   logic                                 s5_dneg_ff;
   logic [rci_pkg::MagW-1:0]             s5_chh_in, s5_chl_in, s5_cll_in;
   logic [rci_pkg::MagW-1:0]             s5_dhh_in, s5_dhl_in, s5_dll_in;
   logic [rci_pkg::MagW-1:0]             s5_chh_ff, s5_chl_ff, s5_cll_ff;
   logic [rci_pkg::MagW-1:0]             s5_dhh_ff, s5_dhl_ff, s5_dll_ff;
   logic [rci_pkg::RlPW+HW-1:0]          s5_rlx;
   logic [rci_pkg::RlW-1:0]              s5_rl_in, s5_rl_ff;
   // front stage six
   rci_pkg::ray_type                     s6_ray_ff;
   logic [rci_pkg::L2W-1:0]              s6_l2_ff;
   logic [rci_pkg::MagW-1:0]             s6_dm_ff;
   logic                                 s6_dneg_ff;
   logic [rci_pkg::SqW-1:0]              s6_cr2_in, s6_dot2_in, s6_cr2_ff, s6_dot2_ff;
   logic [rci_pkg::RlW-1:0]              s6_rl_ff;
   // hit decision
   logic                                 s7_lt, s7_ge;

   rci_pkg::sq_type  sq_in [0:rci_pkg::SqrtStages];
   rci_pkg::sq_type  sq_ff [0:rci_pkg::SqrtStages];
   rci_pkg::k_type   k_in, k_ff;
   rci_pkg::mul_type m_in, m_ff;
   rci_pkg::dv_type  dv_in [0:rci_pkg::DivStages];
   rci_pkg::dv_type  dv_ff [0:rci_pkg::DivStages];

   logic                          rsp_hit_in, rsp_hit_ff;
   logic [CW-1:0]                 rsp_near_x_in, rsp_near_y_in, rsp_far_x_in, rsp_far_y_in;
   logic [CW-1:0]                 rsp_near_x_ff, rsp_near_y_ff, rsp_far_x_ff, rsp_far_y_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // ray direction and center offset
   always_comb begin
      s1_ray_in.ax = req_start_x;
      s1_ray_in.ay = req_start_y;
      s1_ray_in.dx = $signed({req_end_x[CW-1], req_end_x})
                   - $signed({req_start_x[CW-1], req_start_x});
      s1_ray_in.dy = $signed({req_end_y[CW-1], req_end_y})
                   - $signed({req_start_y[CW-1], req_start_y});
      s1_wx_in = $signed({req_center_x[rci_pkg::CenterWidth-1], req_center_x,
                          {rci_pkg::FracBits{1'b0}}})
               - $signed({req_start_x[CW-1], req_start_x});
      s1_wy_in = $signed({req_center_y[rci_pkg::CenterWidth-1], req_center_y,
                          {rci_pkg::FracBits{1'b0}}})
               - $signed({req_start_y[CW-1], req_start_y});
   end

   // squares and cross products
   always_comb begin
      s2_pxx_in  = $signed(s1_ray_ff.dx) * $signed(s1_ray_ff.dx);
      s2_pyy_in  = $signed(s1_ray_ff.dy) * $signed(s1_ray_ff.dy);
      s2_pxw_in  = $signed(s1_ray_ff.dx) * s1_wx_ff;
      s2_pyw_in  = $signed(s1_ray_ff.dy) * s1_wy_ff;
      s2_pxwy_in = $signed(s1_ray_ff.dx) * s1_wy_ff;
      s2_pywx_in = $signed(s1_ray_ff.dy) * s1_wx_ff;
      s2_rr_in   = rci_pkg::RrW'(s1_r_ff) * rci_pkg::RrW'(s1_r_ff);
   end

   always_comb begin
      s3_l2_in    = rci_pkg::L2W'(s2_pxx_ff + s2_pyy_ff);
      s3_dot_in   = $signed({s2_pxw_ff[rci_pkg::ProdW-1], s2_pxw_ff})
                  + $signed({s2_pyw_ff[rci_pkg::ProdW-1], s2_pyw_ff});
      s3_cross_in = $signed({s2_pxwy_ff[rci_pkg::ProdW-1], s2_pxwy_ff})
                  - $signed({s2_pywx_ff[rci_pkg::ProdW-1], s2_pywx_ff});
   end

   // magnitudes and the radius-squared times length-squared partial products
   always_comb begin
      s4_cm_in  = s3_cross_ff[rci_pkg::DotW-1] ? rci_pkg::MagW'(-s3_cross_ff)
                                               : rci_pkg::MagW'(s3_cross_ff);
      s4_dm_in  = s3_dot_ff[rci_pkg::DotW-1] ? rci_pkg::MagW'(-s3_dot_ff)
                                             : rci_pkg::MagW'(s3_dot_ff);
      s4_rlh_in = rci_pkg::RlPW'(s3_rr_ff) * rci_pkg::RlPW'(s3_l2_ff[rci_pkg::L2W-1:HW]);
      s4_rll_in = rci_pkg::RlPW'(s3_rr_ff) * rci_pkg::RlPW'(s3_l2_ff[HW-1:0]);
   end

   always_comb begin
      s5_chh_in = rci_pkg::MagW'(s4_cm_ff[rci_pkg::MagW-1:HW])
                * rci_pkg::MagW'(s4_cm_ff[rci_pkg::MagW-1:HW]);
      s5_chl_in = rci_pkg::MagW'(s4_cm_ff[rci_pkg::MagW-1:HW])
                * rci_pkg::MagW'(s4_cm_ff[HW-1:0]);
      s5_cll_in = rci_pkg::MagW'(s4_cm_ff[HW-1:0]) * rci_pkg::MagW'(s4_cm_ff[HW-1:0]);
      s5_dhh_in = rci_pkg::MagW'(s4_dm_ff[rci_pkg::MagW-1:HW])
                * rci_pkg::MagW'(s4_dm_ff[rci_pkg::MagW-1:HW]);
      s5_dhl_in = rci_pkg::MagW'(s4_dm_ff[rci_pkg::MagW-1:HW])
                * rci_pkg::MagW'(s4_dm_ff[HW-1:0]);
      s5_dll_in = rci_pkg::MagW'(s4_dm_ff[HW-1:0]) * rci_pkg::MagW'(s4_dm_ff[HW-1:0]);
      s5_rlx    = {s4_rlh_ff, {HW{1'b0}}} + (rci_pkg::RlPW+HW)'(s4_rll_ff);
      // the radius carries no fraction bits, so the product is shifted up by 2*FracBits
      s5_rl_in  = {s5_rlx, {(2*rci_pkg::FracBits){1'b0}}};
   end

   always_comb begin
      s6_cr2_in  = {s5_chh_ff, {(2*HW){1'b0}}}
                 + rci_pkg::SqW'({s5_chl_ff, {(HW+1){1'b0}}})
                 + rci_pkg::SqW'(s5_cll_ff);
      s6_dot2_in = {s5_dhh_ff, {(2*HW){1'b0}}}
                 + rci_pkg::SqW'({s5_dhl_ff, {(HW+1){1'b0}}})
                 + rci_pkg::SqW'(s5_dll_ff);
   end

   // hit test, then the discriminant enters the root pipeline
   always_comb begin
      s7_lt = s6_cr2_ff < rci_pkg::SqW'(s6_rl_ff);
      s7_ge = ((rci_pkg::SqW+1)'(s6_dot2_ff) + (rci_pkg::SqW+1)'(s6_cr2_ff))
              >= (rci_pkg::SqW+1)'(s6_rl_ff);
      sq_in[0].hit  = (s6_l2_ff != '0) && s7_lt && !s6_dneg_ff && s7_ge;
      sq_in[0].ray  = s6_ray_ff;
      sq_in[0].l2   = s6_l2_ff;
      sq_in[0].dot  = s6_dm_ff;
      sq_in[0].x    = s6_rl_ff - rci_pkg::RlW'(s6_cr2_ff);
      sq_in[0].rem  = '0;
      sq_in[0].root = '0;
   end

   // one root bit per stage
   for (genvar i = 0; i < rci_pkg::SqrtStages; i++) begin : g_sqrt
      logic [rci_pkg::RemW-1:0] rs;
      logic [rci_pkg::RemW-1:0] trial;
      always_comb begin
         rs    = {sq_ff[i].rem[rci_pkg::RemW-3:0], sq_ff[i].x[rci_pkg::RlW-1 -: 2]};
         trial = rci_pkg::RemW'({sq_ff[i].root, 2'b01});
         sq_in[i+1]   = sq_ff[i];
         sq_in[i+1].x = {sq_ff[i].x[rci_pkg::RlW-3:0], 2'b00};
         if (rs >= trial) begin
            sq_in[i+1].rem  = rs - trial;
            sq_in[i+1].root = {sq_ff[i].root[rci_pkg::RootW-2:0], 1'b1};
         end else begin
            sq_in[i+1].rem  = rs;
            sq_in[i+1].root = {sq_ff[i].root[rci_pkg::RootW-2:0], 1'b0};
         end
      end
   end

   // near and far parameters
   always_comb begin
      k_in.hit = sq_ff[rci_pkg::SqrtStages].hit;
      k_in.ray = sq_ff[rci_pkg::SqrtStages].ray;
      k_in.l2  = sq_ff[rci_pkg::SqrtStages].l2;
      k_in.kn  = rci_pkg::KW'(sq_ff[rci_pkg::SqrtStages].dot)
               - rci_pkg::KW'(sq_ff[rci_pkg::SqrtStages].root);
      k_in.kf  = rci_pkg::KW'(sq_ff[rci_pkg::SqrtStages].dot)
               + rci_pkg::KW'(sq_ff[rci_pkg::SqrtStages].root);
   end

   // direction magnitude times parameter, split in two partial products per lane
   always_comb begin
      logic [rci_pkg::MagDW-1:0]        mx, my;
      logic [Lanes_c-1:0][rci_pkg::MagDW-1:0] md;
      logic [Lanes_c-1:0][rci_pkg::KW-1:0]    kk;
      mx = k_ff.ray.dx[rci_pkg::DiffW-1] ? rci_pkg::MagDW'(-$signed(k_ff.ray.dx))
                                         : rci_pkg::MagDW'(k_ff.ray.dx);
      my = k_ff.ray.dy[rci_pkg::DiffW-1] ? rci_pkg::MagDW'(-$signed(k_ff.ray.dy))
                                         : rci_pkg::MagDW'(k_ff.ray.dy);
      md[rci_pkg::LaneNearX] = mx;
      md[rci_pkg::LaneNearY] = my;
      md[rci_pkg::LaneFarX]  = mx;
      md[rci_pkg::LaneFarY]  = my;
      kk[rci_pkg::LaneNearX] = k_ff.kn;
      kk[rci_pkg::LaneNearY] = k_ff.kn;
      kk[rci_pkg::LaneFarX]  = k_ff.kf;
      kk[rci_pkg::LaneFarY]  = k_ff.kf;
      m_in.hit = k_ff.hit;
      m_in.ax  = k_ff.ray.ax;
      m_in.ay  = k_ff.ray.ay;
      m_in.l2  = k_ff.l2;
      m_in.neg[rci_pkg::LaneNearX] = k_ff.ray.dx[rci_pkg::DiffW-1];
      m_in.neg[rci_pkg::LaneNearY] = k_ff.ray.dy[rci_pkg::DiffW-1];
      m_in.neg[rci_pkg::LaneFarX]  = k_ff.ray.dx[rci_pkg::DiffW-1];
      m_in.neg[rci_pkg::LaneFarY]  = k_ff.ray.dy[rci_pkg::DiffW-1];
      for (int j = 0; j < Lanes_c; j++) begin
         m_in.plo[j] = rci_pkg::PLoW'(md[j]) * rci_pkg::PLoW'(kk[j][rci_pkg::KLoW-1:0]);
         m_in.phi[j] = rci_pkg::PHiW'(md[j])
                     * rci_pkg::PHiW'(kk[j][rci_pkg::KW-1:rci_pkg::KLoW]);
      end
   end

   // doubled numerator plus length squared gives round half away from zero
   always_comb begin
      logic [rci_pkg::NumW-1:0]  num;
      logic [rci_pkg::Num2W-1:0] num2;
      dv_in[0].hit = m_ff.hit;
      dv_in[0].ax  = m_ff.ax;
      dv_in[0].ay  = m_ff.ay;
      dv_in[0].neg = m_ff.neg;
      dv_in[0].den = {m_ff.l2, 1'b0};
      dv_in[0].q   = '0;
      for (int j = 0; j < Lanes_c; j++) begin
         num  = rci_pkg::NumW'({m_ff.phi[j], {rci_pkg::KLoW{1'b0}}})
              + rci_pkg::NumW'(m_ff.plo[j]);
         num2 = {num, 1'b0} + rci_pkg::Num2W'(m_ff.l2);
         dv_in[0].rem[j] = rci_pkg::DenW'(num2[rci_pkg::Num2W-1:rci_pkg::QW]);
         dv_in[0].lo[j]  = num2[rci_pkg::QW-1:0];
      end
   end

   // one quotient bit per stage in each lane
   for (genvar i = 0; i < rci_pkg::DivStages; i++) begin : g_div
      always_comb begin
         logic [rci_pkg::DenW-1:0] t;
         dv_in[i+1] = dv_ff[i];
         for (int j = 0; j < Lanes_c; j++) begin
            t = {dv_ff[i].rem[j][rci_pkg::DenW-2:0], dv_ff[i].lo[j][rci_pkg::QW-1]};
            dv_in[i+1].lo[j] = {dv_ff[i].lo[j][rci_pkg::QW-2:0], 1'b0};
            if (t >= dv_ff[i].den) begin
               dv_in[i+1].rem[j] = t - dv_ff[i].den;
               dv_in[i+1].q[j]   = {dv_ff[i].q[j][rci_pkg::QW-2:0], 1'b1};
            end else begin
               dv_in[i+1].rem[j] = t;
               dv_in[i+1].q[j]   = {dv_ff[i].q[j][rci_pkg::QW-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      rsp_hit_in    = dv_ff[rci_pkg::DivStages].hit;
      rsp_near_x_in = '0;
      rsp_near_y_in = '0;
      rsp_far_x_in  = '0;
      rsp_far_y_in  = '0;
      if (dv_ff[rci_pkg::DivStages].hit) begin
         rsp_near_x_in = rci_pkg::sat_coord(dv_ff[rci_pkg::DivStages].ax,
                            dv_ff[rci_pkg::DivStages].neg[rci_pkg::LaneNearX],
                            dv_ff[rci_pkg::DivStages].q[rci_pkg::LaneNearX]);
         rsp_near_y_in = rci_pkg::sat_coord(dv_ff[rci_pkg::DivStages].ay,
                            dv_ff[rci_pkg::DivStages].neg[rci_pkg::LaneNearY],
                            dv_ff[rci_pkg::DivStages].q[rci_pkg::LaneNearY]);
         rsp_far_x_in  = rci_pkg::sat_coord(dv_ff[rci_pkg::DivStages].ax,
                            dv_ff[rci_pkg::DivStages].neg[rci_pkg::LaneFarX],
                            dv_ff[rci_pkg::DivStages].q[rci_pkg::LaneFarX]);
         rsp_far_y_in  = rci_pkg::sat_coord(dv_ff[rci_pkg::DivStages].ay,
                            dv_ff[rci_pkg::DivStages].neg[rci_pkg::LaneFarY],
                            dv_ff[rci_pkg::DivStages].q[rci_pkg::LaneFarY]);
      end
   end

   // valid bits move with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff        <= '0;
         sv_ff        <= '0;
         kv_ff        <= 1'b0;
         mv_ff        <= 1'b0;
         dv_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         fv_ff        <= {fv_ff[4:0], req_valid};
         sv_ff        <= {sv_ff[rci_pkg::SqrtStages-1:0], fv_ff[5]};
         kv_ff        <= sv_ff[rci_pkg::SqrtStages];
         mv_ff        <= kv_ff;
         dv_vld_ff    <= {dv_vld_ff[rci_pkg::DivStages-1:0], mv_ff};
         rsp_valid_ff <= dv_vld_ff[rci_pkg::DivStages];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ray_ff  <= s1_ray_in;
         s1_wx_ff   <= s1_wx_in;
         s1_wy_ff   <= s1_wy_in;
         s1_r_ff    <= req_circle_radius;
         s2_ray_ff  <= s1_ray_ff;
         s2_pxx_ff  <= s2_pxx_in;
         s2_pyy_ff  <= s2_pyy_in;
         s2_pxw_ff  <= s2_pxw_in;
         s2_pyw_ff  <= s2_pyw_in;
         s2_pxwy_ff <= s2_pxwy_in;
         s2_pywx_ff <= s2_pywx_in;
         s2_rr_ff   <= s2_rr_in;
         s3_ray_ff  <= s2_ray_ff;
         s3_l2_ff   <= s3_l2_in;
         s3_dot_ff  <= s3_dot_in;
         s3_cross_ff <= s3_cross_in;
         s3_rr_ff   <= s2_rr_ff;
         s4_ray_ff  <= s3_ray_ff;
         s4_l2_ff   <= s3_l2_ff;
         s4_cm_ff   <= s4_cm_in;
         s4_dm_ff   <= s4_dm_in;
         s4_dneg_ff <= s3_dot_ff[rci_pkg::DotW-1];
         s4_rlh_ff  <= s4_rlh_in;
         s4_rll_ff  <= s4_rll_in;
         s5_ray_ff  <= s4_ray_ff;
         s5_l2_ff   <= s4_l2_ff;
         s5_dm_ff   <= s4_dm_ff;
         s5_dneg_ff <= s4_dneg_ff;
         s5_chh_ff  <= s5_chh_in;
         s5_chl_ff  <= s5_chl_in;
         s5_cll_ff  <= s5_cll_in;
         s5_dhh_ff  <= s5_dhh_in;
         s5_dhl_ff  <= s5_dhl_in;
         s5_dll_ff  <= s5_dll_in;
         s5_rl_ff   <= s5_rl_in;
         s6_ray_ff  <= s5_ray_ff;
         s6_l2_ff   <= s5_l2_ff;
         s6_dm_ff   <= s5_dm_ff;
         s6_dneg_ff <= s5_dneg_ff;
         s6_cr2_ff  <= s6_cr2_in;
         s6_dot2_ff <= s6_dot2_in;
         s6_rl_ff   <= s5_rl_ff;
         for (int i = 0; i <= rci_pkg::SqrtStages; i++) begin
            sq_ff[i] <= sq_in[i];
         end
         k_ff <= k_in;
         m_ff <= m_in;
         for (int i = 0; i <= rci_pkg::DivStages; i++) begin
            dv_ff[i] <= dv_in[i];
         end
         rsp_hit_ff    <= rsp_hit_in;
         rsp_near_x_ff <= rsp_near_x_in;
         rsp_near_y_ff <= rsp_near_y_in;
         rsp_far_x_ff  <= rsp_far_x_in;
         rsp_far_y_ff  <= rsp_far_y_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_near_x = rsp_near_x_ff;
   assign rsp_near_y = rsp_near_y_ff;
   assign rsp_far_x  = rsp_far_x_ff;
   assign rsp_far_y  = rsp_far_y_ff;

   // a miss carries zero coordinates
   `RCI_ASSERT_IMP(a_miss_zero, rsp_valid_ff && !rsp_hit_ff,
      rsp_near_x_ff == '0 && rsp_near_y_ff == '0 && rsp_far_x_ff == '0 && rsp_far_y_ff == '0)
   // a hit never comes from a zero-length ray
   `RCI_ASSERT_IMP(a_hit_len, sv_ff[0] && sq_ff[0].hit, sq_ff[0].l2 != '0)
   // the root never exceeds the projection on a hit, so the near parameter stays non-negative
   `RCI_ASSERT_IMP(a_near_nonneg, kv_ff && k_ff.hit, !k_ff.kn[rci_pkg::KW-1])
   // the pipeline moves only when the output slot is free or taken
   `RCI_ASSERT_NEXT(a_hold, rsp_valid_ff && rsp_stall && !reset, rsp_valid_ff)

endmodule
